// ===== rtl/core/arpr_pkg.sv =====
// arpr_pkg: shared constants, codes and result type of the arp resolver
package arpr_pkg;

  localparam int CACHE_ENTRIES_DEF   = 16;
  localparam int REQUEST_ENTRIES_DEF = 8;
  localparam int WAITING_SLOTS_DEF   = 16;

  localparam int OUT_LIMIT   = 17;
  localparam int FLUSH_LIMIT = OUT_LIMIT - 1;
  localparam int FCNT_W      = $clog2(FLUSH_LIMIT + 1);

  localparam logic [47:0] BROADCAST_MAC  = 48'hFFFF_FFFF_FFFF;
  localparam logic [15:0] ETYPE_IPV4     = 16'h0800;
  localparam logic [15:0] ETYPE_ARP      = 16'h0806;
  localparam logic [15:0] HW_ETHERNET    = 16'h0001;
  localparam logic [15:0] ARP_OP_REQUEST = 16'h0001;

  localparam logic [31:0] LIFETIME_RESET = 32'd30000;
  localparam logic [31:0] HOLDOFF_RESET  = 32'd5000;

  typedef enum logic [1:0] {
    CFG_OWN_MAC  = 2'd0,
    CFG_OWN_IP   = 2'd1,
    CFG_LIFETIME = 2'd2,
    CFG_HOLDOFF  = 2'd3
  } cfg_index_t;

  typedef enum logic [1:0] {
    OP_SEND = 2'd0,
    OP_RECV = 2'd1,
    OP_TICK = 2'd2
  } opcode_t;

  typedef enum logic [2:0] {
    K_IPV4      = 3'd0,
    K_ARP_REQ   = 3'd1,
    K_ARP_REPLY = 3'd2,
    K_DELIVER   = 3'd3,
    K_DROP      = 3'd4
  } kind_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [47:0] mac;
    logic [31:0] tip;
    logic [7:0]  tag;
  } result_t;

endpackage

// ===== rtl/core/arpr_ram.sv =====
// arpr_ram: generic single write port ram with registered read
module arpr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/arp_resolver_with_aging_top.sv =====
// arp_resolver_with_aging_top: arp cache with aging, request table and parked datagrams
//
// Works on one input beat at a time; in_ready is high only while no beat is in work.
// Cache, request and waiting tables live in three rams with registered read;
// their valid bits are flip-flops, so reset clears them at once and no clearing pass
// is needed. Each scan skips an invalid entry and for a valid entry reads it, then
// compares or updates it. A send scans the cache and, on a miss, the request table
// and then parks the datagram, with a further scan of the request table when it is
// full; a learning ARP frame scans the cache (twice when the cache is full) and then
// the waiting slots for the flush; a tick scans the cache and the request table.
// Results leave through a one-entry hold stage and an output register; a stalled
// output holds the scan.
module arp_resolver_with_aging_top #(
  parameter int CACHE_ENTRIES   = arpr_pkg::CACHE_ENTRIES_DEF,
  parameter int REQUEST_ENTRIES = arpr_pkg::REQUEST_ENTRIES_DEF,
  parameter int WAITING_SLOTS   = arpr_pkg::WAITING_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [47:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [31:0] gateway_ip,
  input  logic [7:0]  datagram_tag,
  input  logic [47:0] frame_dst_mac,
  input  logic [15:0] frame_type,
  input  logic [15:0] arp_hardware_type,
  input  logic [15:0] arp_protocol_type,
  input  logic [15:0] arp_operation,
  input  logic [47:0] sender_mac,
  input  logic [31:0] sender_ip,
  input  logic [31:0] target_ip,
  input  logic [31:0] elapsed_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  kind,
  output logic [47:0] dest_mac,
  output logic [31:0] arp_target_address,
  output logic [7:0]  out_tag,
  output logic        last
);

  localparam int CW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int RW = (REQUEST_ENTRIES > 1) ? $clog2(REQUEST_ENTRIES) : 1;
  localparam int WW = (WAITING_SLOTS > 1) ? $clog2(WAITING_SLOTS) : 1;
  localparam logic [CW-1:0] C_LAST = CW'(CACHE_ENTRIES - 1);
  localparam logic [RW-1:0] R_LAST = RW'(REQUEST_ENTRIES - 1);
  localparam logic [WW-1:0] W_LAST = WW'(WAITING_SLOTS - 1);
  localparam int FCNT_W = arpr_pkg::FCNT_W;

  typedef struct packed {
    logic [31:0] ip;
    logic [47:0] mac;
    logic [31:0] age;
  } cache_ent_t;

  typedef struct packed {
    logic [31:0] ip;
    logic [31:0] age;
  } req_ent_t;

  typedef struct packed {
    logic [31:0] ip;
    logic [7:0]  tag;
  } wait_ent_t;

  typedef enum logic [3:0] {
    IDLE, CF, RF, RQ, RV, PARK, FILT, LF, LV, LW, FL, RPL, TKC, TKR, FIN
  } state_t;

  state_t state;

  logic [47:0] own_mac;
  logic [31:0] own_ip;
  logic [31:0] lifetime;
  logic [31:0] holdoff;

  logic [31:0] nh_ip;
  logic [7:0]  tag;
  logic [47:0] dmac;
  logic [15:0] ftype;
  logic [15:0] hwt;
  logic [15:0] prt;
  logic [15:0] aop;
  logic [47:0] smac;
  logic [31:0] sip;
  logic [31:0] tip;
  logic [31:0] elapsed;

  logic [CACHE_ENTRIES-1:0]   cvalid;
  logic [REQUEST_ENTRIES-1:0] rvalid;
  logic [WAITING_SLOTS-1:0]   wvalid;

  logic [CW-1:0]     cidx;
  logic [RW-1:0]     ridx;
  logic [WW-1:0]     widx;
  logic              ph;
  logic              rfound;
  logic [31:0]       best_age;
  logic [CW-1:0]     best_c;
  logic [RW-1:0]     best_r;
  logic [CW-1:0]     lslot;
  logic [FCNT_W-1:0] fcnt;

  logic             c_we;
  logic [CW-1:0]    c_wa;
  cache_ent_t       c_wd;
  cache_ent_t       c_rd;
  logic             r_we;
  logic [RW-1:0]    r_wa;
  req_ent_t         r_wd;
  req_ent_t         r_rd;
  logic             w_we;
  logic [WW-1:0]    w_wa;
  wait_ent_t        w_wd;
  wait_ent_t        w_rd;

  logic              p_valid;
  arpr_pkg::result_t p_res;
  logic              o_valid;
  arpr_pkg::result_t o_res;
  logic              o_last;

  logic              out_free;
  logic              can_put;
  logic              put_req;
  arpr_pkg::result_t put_res;

  logic          c_free_found;
  logic [CW-1:0] c_free_idx;
  logic          r_free_found;
  logic [RW-1:0] r_free_idx;
  logic          w_free_found;
  logic [WW-1:0] w_free_idx;

  logic          c_cand;
  logic [CW-1:0] c_best_end;
  logic          r_cand;
  logic [RW-1:0] r_best_end;
  logic          reply_due;

  arpr_ram #(.WIDTH($bits(cache_ent_t)), .DEPTH(CACHE_ENTRIES)) u_cache_ram (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_wa),
    .wdata (c_wd),
    .raddr (cidx),
    .rdata (c_rd)
  );

  arpr_ram #(.WIDTH($bits(req_ent_t)), .DEPTH(REQUEST_ENTRIES)) u_req_ram (
    .clk   (clk),
    .we    (r_we),
    .waddr (r_wa),
    .wdata (r_wd),
    .raddr (ridx),
    .rdata (r_rd)
  );

  arpr_ram #(.WIDTH($bits(wait_ent_t)), .DEPTH(WAITING_SLOTS)) u_wait_ram (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_wa),
    .wdata (w_wd),
    .raddr (widx),
    .rdata (w_rd)
  );

  // first free entry of each table
  always_comb begin
    c_free_found = 1'b0;
    c_free_idx   = '0;
    for (int i = CACHE_ENTRIES - 1; i >= 0; i--) begin
      if (!cvalid[i]) begin
        c_free_found = 1'b1;
        c_free_idx   = CW'(i);
      end
    end
    r_free_found = 1'b0;
    r_free_idx   = '0;
    for (int i = REQUEST_ENTRIES - 1; i >= 0; i--) begin
      if (!rvalid[i]) begin
        r_free_found = 1'b1;
        r_free_idx   = RW'(i);
      end
    end
    w_free_found = 1'b0;
    w_free_idx   = '0;
    for (int i = WAITING_SLOTS - 1; i >= 0; i--) begin
      if (!wvalid[i]) begin
        w_free_found = 1'b1;
        w_free_idx   = WW'(i);
      end
    end
  end

  assign c_cand     = (cidx == '0) || (c_rd.age < best_age);
  assign c_best_end = c_cand ? cidx : best_c;
  assign r_cand     = (ridx == '0) || (r_rd.age < best_age);
  assign r_best_end = r_cand ? ridx : best_r;
  assign reply_due  = (aop == arpr_pkg::ARP_OP_REQUEST) && (tip == own_ip);

  assign out_free = !o_valid || out_ready;
  assign can_put  = !p_valid || out_free;

  always_comb begin
    put_req = 1'b0;
    put_res = '0;
    case (state)
      CF: begin
        if (ph && c_rd.ip == nh_ip) begin
          put_req = 1'b1;
          put_res = '{kind: arpr_pkg::K_IPV4, mac: c_rd.mac, tip: 32'd0, tag: tag};
        end
      end
      RQ: begin
        if (!rfound) begin
          put_req = 1'b1;
          put_res = '{kind: arpr_pkg::K_ARP_REQ, mac: arpr_pkg::BROADCAST_MAC,
                      tip: nh_ip, tag: 8'd0};
        end
      end
      PARK: begin
        if (!w_free_found) begin
          put_req = 1'b1;
          put_res = '{kind: arpr_pkg::K_DROP, mac: 48'd0, tip: 32'd0, tag: tag};
        end
      end
      FILT: begin
        if ((dmac == own_mac || dmac == arpr_pkg::BROADCAST_MAC) &&
            ftype == arpr_pkg::ETYPE_IPV4) begin
          put_req = 1'b1;
          put_res = '{kind: arpr_pkg::K_DELIVER, mac: 48'd0, tip: 32'd0, tag: tag};
        end
      end
      FL: begin
        if (ph && w_rd.ip == sip && fcnt < FCNT_W'(arpr_pkg::FLUSH_LIMIT)) begin
          put_req = 1'b1;
          put_res = '{kind: arpr_pkg::K_IPV4, mac: smac, tip: 32'd0, tag: w_rd.tag};
        end
      end
      RPL: begin
        if (reply_due) begin
          put_req = 1'b1;
          put_res = '{kind: arpr_pkg::K_ARP_REPLY, mac: smac, tip: sip, tag: 8'd0};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      own_mac  <= '0;
      own_ip   <= '0;
      lifetime <= arpr_pkg::LIFETIME_RESET;
      holdoff  <= arpr_pkg::HOLDOFF_RESET;
      cvalid   <= '0;
      rvalid   <= '0;
      wvalid   <= '0;
      p_valid  <= 1'b0;
      o_valid  <= 1'b0;
      c_we     <= 1'b0;
      r_we     <= 1'b0;
      w_we     <= 1'b0;
    end else begin
      c_we <= 1'b0;
      r_we <= 1'b0;
      w_we <= 1'b0;

      if (cfg_write) begin
        case (arpr_pkg::cfg_index_t'(cfg_index))
          arpr_pkg::CFG_OWN_MAC:  own_mac  <= cfg_data;
          arpr_pkg::CFG_OWN_IP:   own_ip   <= cfg_data[31:0];
          arpr_pkg::CFG_LIFETIME: lifetime <= cfg_data[31:0];
          arpr_pkg::CFG_HOLDOFF:  holdoff  <= cfg_data[31:0];
          default: ;
        endcase
      end

      if (out_ready) begin
        o_valid <= 1'b0;
      end

      if (put_req && can_put) begin
        if (p_valid) begin
          o_valid <= 1'b1;
          o_res   <= p_res;
          o_last  <= 1'b0;
        end
        p_valid <= 1'b1;
        p_res   <= put_res;
      end

      case (state)
        IDLE: begin
          if (in_valid) begin
            nh_ip   <= gateway_ip;
            tag     <= datagram_tag;
            dmac    <= frame_dst_mac;
            ftype   <= frame_type;
            hwt     <= arp_hardware_type;
            prt     <= arp_protocol_type;
            aop     <= arp_operation;
            smac    <= sender_mac;
            sip     <= sender_ip;
            tip     <= target_ip;
            elapsed <= elapsed_ms;
            cidx    <= '0;
            ridx    <= '0;
            widx    <= '0;
            ph      <= 1'b0;
            rfound  <= 1'b0;
            fcnt    <= '0;
            case (arpr_pkg::opcode_t'(opcode))
              arpr_pkg::OP_SEND: state <= CF;
              arpr_pkg::OP_RECV: state <= FILT;
              arpr_pkg::OP_TICK: state <= TKC;
              default:           state <= FIN;
            endcase
          end
        end

        // send: cache lookup
        CF: begin
          if (!ph && cvalid[cidx]) begin
            ph <= 1'b1;
          end else if (ph && c_rd.ip == nh_ip) begin
            if (can_put) begin
              state <= FIN;
            end
          end else begin
            ph <= 1'b0;
            if (cidx == C_LAST) begin
              state <= RF;
            end else begin
              cidx <= cidx + 1'b1;
            end
          end
        end

        // send: outstanding request lookup
        RF: begin
          if (!ph && rvalid[ridx]) begin
            ph <= 1'b1;
          end else if (ph && r_rd.ip == nh_ip) begin
            rfound <= 1'b1;
            ph     <= 1'b0;
            state  <= RQ;
          end else begin
            ph <= 1'b0;
            if (ridx == R_LAST) begin
              state <= RQ;
            end else begin
              ridx <= ridx + 1'b1;
            end
          end
        end

        RQ: begin
          if (rfound) begin
            state <= PARK;
          end else if (can_put) begin
            if (r_free_found) begin
              r_we                <= 1'b1;
              r_wa                <= r_free_idx;
              r_wd                <= '{ip: nh_ip, age: holdoff};
              rvalid[r_free_idx]  <= 1'b1;
              state               <= PARK;
            end else begin
              ridx  <= '0;
              ph    <= 1'b0;
              state <= RV;
            end
          end
        end

        // send: replace request with least hold-off left
        RV: begin
          if (!ph) begin
            ph <= 1'b1;
          end else begin
            ph <= 1'b0;
            if (r_cand) begin
              best_age <= r_rd.age;
              best_r   <= ridx;
            end
            if (ridx == R_LAST) begin
              r_we  <= 1'b1;
              r_wa  <= r_best_end;
              r_wd  <= '{ip: nh_ip, age: holdoff};
              state <= PARK;
            end else begin
              ridx <= ridx + 1'b1;
            end
          end
        end

        PARK: begin
          if (w_free_found) begin
            w_we               <= 1'b1;
            w_wa               <= w_free_idx;
            w_wd               <= '{ip: nh_ip, tag: tag};
            wvalid[w_free_idx] <= 1'b1;
            state              <= FIN;
          end else if (can_put) begin
            state <= FIN;
          end
        end

        // receive: destination and type filter
        FILT: begin
          if (dmac != own_mac && dmac != arpr_pkg::BROADCAST_MAC) begin
            state <= FIN;
          end else if (ftype == arpr_pkg::ETYPE_IPV4) begin
            if (can_put) begin
              state <= FIN;
            end
          end else if (ftype != arpr_pkg::ETYPE_ARP || hwt != arpr_pkg::HW_ETHERNET ||
                       prt != arpr_pkg::ETYPE_IPV4) begin
            state <= FIN;
          end else begin
            state <= LF;
          end
        end

        // learn: known sender
        LF: begin
          if (!ph && cvalid[cidx]) begin
            ph <= 1'b1;
          end else if (ph && c_rd.ip == sip) begin
            lslot <= cidx;
            ph    <= 1'b0;
            state <= LW;
          end else begin
            ph <= 1'b0;
            if (cidx == C_LAST) begin
              if (c_free_found) begin
                lslot <= c_free_idx;
                state <= LW;
              end else begin
                cidx  <= '0;
                state <= LV;
              end
            end else begin
              cidx <= cidx + 1'b1;
            end
          end
        end

        // learn: replace entry with least lifetime left
        LV: begin
          if (!ph) begin
            ph <= 1'b1;
          end else begin
            ph <= 1'b0;
            if (c_cand) begin
              best_age <= c_rd.age;
              best_c   <= cidx;
            end
            if (cidx == C_LAST) begin
              lslot <= c_best_end;
              state <= LW;
            end else begin
              cidx <= cidx + 1'b1;
            end
          end
        end

        LW: begin
          c_we          <= 1'b1;
          c_wa          <= lslot;
          c_wd          <= '{ip: sip, mac: smac, age: lifetime};
          cvalid[lslot] <= 1'b1;
          widx          <= '0;
          ph            <= 1'b0;
          state         <= FL;
        end

        // flush parked datagrams of the learned address
        FL: begin
          if (!ph && wvalid[widx]) begin
            ph <= 1'b1;
          end else if (put_req && !can_put) begin
            ph <= 1'b1;
          end else begin
            ph <= 1'b0;
            if (put_req) begin
              wvalid[widx] <= 1'b0;
              fcnt         <= fcnt + 1'b1;
            end
            if (widx == W_LAST) begin
              state <= RPL;
            end else begin
              widx <= widx + 1'b1;
            end
          end
        end

        RPL: begin
          if (!reply_due || can_put) begin
            state <= FIN;
          end
        end

        // tick: age the cache
        TKC: begin
          if (!ph && cvalid[cidx]) begin
            ph <= 1'b1;
          end else begin
            if (ph) begin
              if (c_rd.age < elapsed) begin
                cvalid[cidx] <= 1'b0;
              end else begin
                c_we <= 1'b1;
                c_wa <= cidx;
                c_wd <= '{ip: c_rd.ip, mac: c_rd.mac, age: c_rd.age - elapsed};
              end
            end
            ph <= 1'b0;
            if (cidx == C_LAST) begin
              state <= TKR;
            end else begin
              cidx <= cidx + 1'b1;
            end
          end
        end

        // tick: age the request table
        TKR: begin
          if (!ph && rvalid[ridx]) begin
            ph <= 1'b1;
          end else begin
            if (ph) begin
              if (r_rd.age < elapsed) begin
                rvalid[ridx] <= 1'b0;
              end else begin
                r_we <= 1'b1;
                r_wa <= ridx;
                r_wd <= '{ip: r_rd.ip, age: r_rd.age - elapsed};
              end
            end
            ph <= 1'b0;
            if (ridx == R_LAST) begin
              state <= FIN;
            end else begin
              ridx <= ridx + 1'b1;
            end
          end
        end

        // hand the held result out as the final beat
        FIN: begin
          if (!p_valid) begin
            state <= IDLE;
          end else if (out_free) begin
            o_valid <= 1'b1;
            o_res   <= p_res;
            o_last  <= 1'b1;
            p_valid <= 1'b0;
            state   <= IDLE;
          end
        end

        default: state <= IDLE;
      endcase
    end
  end

  assign in_ready           = (state == IDLE);
  assign out_valid          = o_valid;
  assign kind               = o_res.kind;
  assign dest_mac           = o_res.mac;
  assign arp_target_address = o_res.tip;
  assign out_tag            = o_res.tag;
  assign last               = o_last;

endmodule
